### rtl/bst_pkg.sv
// Shared types, codes and constants for the BSON stream tokenizer.
package bst_pkg;

  localparam int unsigned DefMaxDepth = 32;

  // Byte roles
  localparam logic [3:0] ROLE_SKIP      = 4'd0;
  localparam logic [3:0] ROLE_DOC_LEN   = 4'd1;
  localparam logic [3:0] ROLE_TYPE      = 4'd2;
  localparam logic [3:0] ROLE_NAME      = 4'd3;
  localparam logic [3:0] ROLE_NAME_END  = 4'd4;
  localparam logic [3:0] ROLE_VAL_LEN   = 4'd5;
  localparam logic [3:0] ROLE_SUBTYPE   = 4'd6;
  localparam logic [3:0] ROLE_BODY      = 4'd7;
  localparam logic [3:0] ROLE_STR_END   = 4'd8;
  localparam logic [3:0] ROLE_DOC_END   = 4'd9;
  localparam logic [3:0] ROLE_TRAILING  = 4'd10;

  // Error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_UNEXP_END  = 3'd1;
  localparam logic [2:0] ERR_TOO_SHORT  = 3'd2;
  localparam logic [2:0] ERR_BAD_SIZE   = 3'd3;
  localparam logic [2:0] ERR_BAD_TYPE   = 3'd4;
  localparam logic [2:0] ERR_BAD_SUB    = 3'd5;
  localparam logic [2:0] ERR_TOO_DEEP   = 3'd6;

  // Configuration register indexes
  localparam logic [7:0] REG_BUFFER_LENGTH = 8'd0;
  localparam logic [7:0] REG_START_OFFSET  = 8'd1;

  typedef enum logic [4:0] {
    PH_LEN       = 5'd0,
    PH_TYPE      = 5'd1,
    PH_NAME      = 5'd2,
    PH_FIXED     = 5'd3,
    PH_STRLEN    = 5'd4,
    PH_STRBODY   = 5'd5,
    PH_DBSTRLEN  = 5'd6,
    PH_DBSTRBODY = 5'd7,
    PH_RE1       = 5'd8,
    PH_RE2       = 5'd9,
    PH_BINLEN    = 5'd10,
    PH_BINSUB    = 5'd11,
    PH_BINBODY   = 5'd12,
    PH_SCSIZE    = 5'd13,
    PH_SCSTRLEN  = 5'd14,
    PH_SCSTRBODY = 5'd15,
    PH_DONE      = 5'd16
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  byte_role;
    logic [7:0]  element_type;
    logic [5:0]  nest_depth;
    logic [2:0]  error_code;
    logic        doc_done;
    logic [31:0] end_offset;
  } out_item_t;

  typedef struct packed {
    logic [31:0] buffer_length;
    logic [31:0] start_offset;
  } cfg_regs_t;

endpackage

### rtl/bst_parse.sv
// Parser state registers and the per-byte next-state and result logic.
module bst_parse #(
  parameter int unsigned MAX_DEPTH = bst_pkg::DefMaxDepth
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  bst_pkg::in_item_t  item,
  input  bst_pkg::cfg_regs_t cfg,
  output bst_pkg::out_item_t result
);

  localparam int DW = $clog2(MAX_DEPTH + 2);
  localparam logic [DW-1:0] DepthLimit = DW'(MAX_DEPTH);

  logic [31:0]      byte_position, byte_position_next;
  bst_pkg::phase_t  parse_phase, parse_phase_next;
  logic [3:0]       field_counter, field_counter_next;
  logic [31:0]      length_accumulator, length_accumulator_next;
  logic [7:0]       current_type, current_type_next;
  logic [DW-1:0]    depth_counter, depth_counter_next;
  logic [2:0]       sticky_error, sticky_error_next;

  // Hold state between accepted bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position      <= '0;
      parse_phase        <= bst_pkg::PH_LEN;
      field_counter      <= '0;
      length_accumulator <= '0;
      current_type       <= '0;
      depth_counter      <= '0;
      sticky_error       <= bst_pkg::ERR_NONE;
    end else if (step) begin
      byte_position      <= byte_position_next;
      parse_phase        <= parse_phase_next;
      field_counter      <= field_counter_next;
      length_accumulator <= length_accumulator_next;
      current_type       <= current_type_next;
      depth_counter      <= depth_counter_next;
      sticky_error       <= sticky_error_next;
    end
  end

  // Tag one byte and advance the parser
  always_comb begin
    logic [31:0]    pos;
    logic [7:0]     b;
    logic [3:0]     role;
    logic [DW-1:0]  shown;
    logic [31:0]    shown_wide;
    logic           done;
    logic           word_done;
    logic [31:0]    acc_w;
    logic [3:0]     fc_w;
    logic [31:0]    need;
    logic [31:0]    left;

    b = item.data_byte;
    if (item.first_byte) begin
      pos                     = '0;
      parse_phase_next        = bst_pkg::PH_LEN;
      field_counter_next      = '0;
      length_accumulator_next = '0;
      current_type_next       = '0;
      depth_counter_next      = '0;
      sticky_error_next       = bst_pkg::ERR_NONE;
    end else begin
      pos                     = byte_position;
      parse_phase_next        = parse_phase;
      field_counter_next      = field_counter;
      length_accumulator_next = length_accumulator;
      current_type_next       = current_type;
      depth_counter_next      = depth_counter;
      sticky_error_next       = sticky_error;
    end
    shown = depth_counter_next;
    done  = 1'b0;
    role  = bst_pkg::ROLE_TRAILING;

    // Little-endian word collection shared by all length phases
    acc_w = length_accumulator_next |
            (32'(b) << {field_counter_next[1:0], 3'b000});
    fc_w  = field_counter_next + 4'd1;
    word_done = (fc_w >= 4'd4);
    need = acc_w - 32'd4;
    left = cfg.buffer_length - pos - 32'd1;

    if (pos >= cfg.buffer_length) begin
      if (sticky_error_next == bst_pkg::ERR_NONE && parse_phase_next != bst_pkg::PH_DONE)
        sticky_error_next = bst_pkg::ERR_UNEXP_END;
    end else if (sticky_error_next != bst_pkg::ERR_NONE ||
                 parse_phase_next == bst_pkg::PH_DONE) begin
      role = bst_pkg::ROLE_TRAILING;
    end else if (pos < cfg.start_offset) begin
      role = bst_pkg::ROLE_SKIP;
    end else begin
      case (parse_phase_next)
        bst_pkg::PH_LEN: begin
          role = bst_pkg::ROLE_DOC_LEN;
          if (field_counter_next == '0) begin
            depth_counter_next = depth_counter_next + DW'(1);
            shown = depth_counter_next;
          end
          if (field_counter_next == '0 && depth_counter_next > DepthLimit) begin
            sticky_error_next = bst_pkg::ERR_TOO_DEEP;
          end else begin
            length_accumulator_next = acc_w;
            field_counter_next = word_done ? 4'd0 : fc_w;
            if (word_done) begin
              if (need > left) begin
                sticky_error_next = bst_pkg::ERR_TOO_SHORT;
              end else if (acc_w < 32'd5) begin
                sticky_error_next = bst_pkg::ERR_BAD_SIZE;
              end else begin
                parse_phase_next = bst_pkg::PH_TYPE;
                length_accumulator_next = '0;
              end
            end
          end
        end
        bst_pkg::PH_TYPE: begin
          current_type_next = b;
          if (b == 8'h00) begin
            role = bst_pkg::ROLE_DOC_END;
            depth_counter_next = depth_counter_next - DW'(1);
            if (depth_counter_next == '0) begin
              parse_phase_next = bst_pkg::PH_DONE;
              done = 1'b1;
            end
          end else begin
            role = bst_pkg::ROLE_TYPE;
            parse_phase_next = bst_pkg::PH_NAME;
            field_counter_next = '0;
            length_accumulator_next = '0;
          end
        end
        bst_pkg::PH_NAME: begin
          if (b != 8'h00) begin
            role = bst_pkg::ROLE_NAME;
          end else begin
            role = bst_pkg::ROLE_NAME_END;
            // Pick the value layout from the element type
            case (current_type_next) inside
              8'h01, 8'h09, 8'h11, 8'h12, 8'h3f: begin
                parse_phase_next = bst_pkg::PH_FIXED;
                field_counter_next = 4'd8;
              end
              8'h07: begin
                parse_phase_next = bst_pkg::PH_FIXED;
                field_counter_next = 4'd12;
              end
              8'h08: begin
                parse_phase_next = bst_pkg::PH_FIXED;
                field_counter_next = 4'd1;
              end
              8'h10: begin
                parse_phase_next = bst_pkg::PH_FIXED;
                field_counter_next = 4'd4;
              end
              8'h02, 8'h0D, 8'h0E: begin
                parse_phase_next = bst_pkg::PH_STRLEN;
                field_counter_next = '0;
                length_accumulator_next = '0;
              end
              8'h03, 8'h04: begin
                parse_phase_next = bst_pkg::PH_LEN;
                field_counter_next = '0;
                length_accumulator_next = '0;
              end
              8'h05: begin
                parse_phase_next = bst_pkg::PH_BINLEN;
                field_counter_next = '0;
                length_accumulator_next = '0;
              end
              8'h06, 8'h0A, 8'h7f, 8'hff: begin
                parse_phase_next = bst_pkg::PH_TYPE;
                field_counter_next = '0;
                length_accumulator_next = '0;
              end
              8'h0B: begin
                parse_phase_next = bst_pkg::PH_RE1;
                field_counter_next = '0;
                length_accumulator_next = '0;
              end
              8'h0C: begin
                parse_phase_next = bst_pkg::PH_DBSTRLEN;
                field_counter_next = '0;
                length_accumulator_next = '0;
              end
              8'h0F: begin
                parse_phase_next = bst_pkg::PH_SCSIZE;
                field_counter_next = '0;
                length_accumulator_next = '0;
              end
              default: sticky_error_next = bst_pkg::ERR_BAD_TYPE;
            endcase
          end
        end
        bst_pkg::PH_FIXED: begin
          role = bst_pkg::ROLE_BODY;
          field_counter_next = field_counter_next - 4'd1;
          if (field_counter_next == '0) begin
            parse_phase_next = bst_pkg::PH_TYPE;
            length_accumulator_next = '0;
          end
        end
        bst_pkg::PH_STRLEN, bst_pkg::PH_DBSTRLEN, bst_pkg::PH_SCSTRLEN,
        bst_pkg::PH_BINLEN, bst_pkg::PH_SCSIZE: begin
          role = bst_pkg::ROLE_VAL_LEN;
          length_accumulator_next = acc_w;
          field_counter_next = word_done ? 4'd0 : fc_w;
          if (word_done) begin
            case (parse_phase_next)
              bst_pkg::PH_BINLEN: parse_phase_next = bst_pkg::PH_BINSUB;
              bst_pkg::PH_SCSIZE: begin
                parse_phase_next = bst_pkg::PH_SCSTRLEN;
                length_accumulator_next = '0;
              end
              bst_pkg::PH_STRLEN: begin
                parse_phase_next = bst_pkg::PH_STRBODY;
                length_accumulator_next = '0;
              end
              bst_pkg::PH_DBSTRLEN: begin
                parse_phase_next = bst_pkg::PH_DBSTRBODY;
                length_accumulator_next = '0;
              end
              default: begin
                parse_phase_next = bst_pkg::PH_SCSTRBODY;
                length_accumulator_next = '0;
              end
            endcase
          end
        end
        bst_pkg::PH_STRBODY, bst_pkg::PH_DBSTRBODY, bst_pkg::PH_RE1,
        bst_pkg::PH_RE2, bst_pkg::PH_SCSTRBODY: begin
          if (b != 8'h00) begin
            role = bst_pkg::ROLE_BODY;
          end else begin
            role = bst_pkg::ROLE_STR_END;
            case (parse_phase_next)
              bst_pkg::PH_DBSTRBODY: begin
                parse_phase_next = bst_pkg::PH_FIXED;
                field_counter_next = 4'd12;
              end
              bst_pkg::PH_RE1: begin
                parse_phase_next = bst_pkg::PH_RE2;
                field_counter_next = '0;
                length_accumulator_next = '0;
              end
              bst_pkg::PH_SCSTRBODY: begin
                parse_phase_next = bst_pkg::PH_LEN;
                field_counter_next = '0;
                length_accumulator_next = '0;
              end
              default: begin
                parse_phase_next = bst_pkg::PH_TYPE;
                field_counter_next = '0;
                length_accumulator_next = '0;
              end
            endcase
          end
        end
        bst_pkg::PH_BINSUB: begin
          role = bst_pkg::ROLE_SUBTYPE;
          if (!(b inside {8'h00, 8'h01, 8'h02, 8'h03, 8'h05, 8'h80})) begin
            sticky_error_next = bst_pkg::ERR_BAD_SUB;
          end else if (length_accumulator_next == '0) begin
            parse_phase_next = bst_pkg::PH_TYPE;
            field_counter_next = '0;
          end else begin
            parse_phase_next = bst_pkg::PH_BINBODY;
          end
        end
        bst_pkg::PH_BINBODY: begin
          role = bst_pkg::ROLE_BODY;
          length_accumulator_next = length_accumulator_next - 32'd1;
          if (length_accumulator_next == '0) begin
            parse_phase_next = bst_pkg::PH_TYPE;
            field_counter_next = '0;
          end
        end
        default: role = bst_pkg::ROLE_TRAILING;
      endcase
    end

    // Flag a buffer that ends before the document does
    if (cfg.buffer_length != '0 && pos == cfg.buffer_length - 32'd1 &&
        sticky_error_next == bst_pkg::ERR_NONE && parse_phase_next != bst_pkg::PH_DONE)
      sticky_error_next = bst_pkg::ERR_UNEXP_END;

    byte_position_next = (pos == 32'hFFFF_FFFF) ? pos : pos + 32'd1;

    shown_wide = 32'(shown);
    result.byte_role    = role;
    result.element_type = current_type_next;
    result.nest_depth   = shown_wide[5:0];
    result.error_code   = sticky_error_next;
    result.doc_done     = done;
    result.end_offset   = done ? pos + 32'd1 : 32'd0;
  end

endmodule

### rtl/bson_stream_tokenizer.sv
// Top level: configuration registers, handshakes and the result register.
//
// Tags each byte of a BSON buffer with its role in one document, one byte per
// cycle: the result of a byte is written into the output register at the edge
// that accepts it, and a new byte is taken in every cycle in which the output
// register is empty or being drained. The per-byte work is one pass of parser
// logic over a 32-bit position compare and length check. Configuration writes
// are taken at any time and should be made only while the block is idle.
module bson_stream_tokenizer #(
  parameter int unsigned MAX_DEPTH = bst_pkg::DefMaxDepth
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bst_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bst_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  bst_pkg::cfg_regs_t cfg;
  bst_pkg::out_item_t result;
  logic               step;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign step      = in_valid && in_ready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.buffer_length <= 32'd1;
      cfg.start_offset  <= 32'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        bst_pkg::REG_BUFFER_LENGTH: cfg.buffer_length <= cfg_data;
        bst_pkg::REG_START_OFFSET:  cfg.start_offset  <= cfg_data;
        default: ;
      endcase
    end
  end

  bst_parse #(.MAX_DEPTH(MAX_DEPTH)) u_parse (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (in_data),
    .cfg    (cfg),
    .result (result)
  );

  // Hold the result until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= result;
    end
  end

endmodule

### tb/sv/tb.sv
// Testbench for the BSON stream tokenizer: random and directed byte streams, checked per byte.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned DEPTH_LIMIT = 32;
  localparam int unsigned STALL_LIMIT = 20000;

  // Scoreboard: predicts the role of each accepted byte and checks results in order.
  class token_scoreboard;
    logic [31:0]        buf_len;
    logic [31:0]        skip_len;
    logic [31:0]        pos;
    bst_pkg::phase_t    phase;
    logic [31:0]        count;
    logic [31:0]        acc;
    logic [7:0]         cur_type;
    logic [31:0]        depth;
    logic [2:0]         err;
    bst_pkg::out_item_t pending[$];
    int                 fails;

    function new();
      buf_len = 1;
      skip_len = 0;
      fails = 0;
      clear();
    endfunction

    function void clear();
      pos = 0;
      phase = bst_pkg::PH_LEN;
      count = 0;
      acc = 0;
      cur_type = 0;
      depth = 0;
      err = bst_pkg::ERR_NONE;
    endfunction

    function void write_reg(logic [7:0] idx, logic [31:0] val);
      if (idx == bst_pkg::REG_BUFFER_LENGTH) buf_len = val;
      else if (idx == bst_pkg::REG_START_OFFSET) skip_len = val;
    endfunction

    function void enter(bst_pkg::phase_t p);
      phase = p;
      count = 0;
      acc = 0;
    endfunction

    function void enter_fixed(logic [31:0] n);
      phase = bst_pkg::PH_FIXED;
      count = n;
    endfunction

    // Collect a little-endian word; true on its fourth byte.
    function bit word_byte(logic [7:0] b);
      acc = acc | (32'(b) << ((count & 3) * 8));
      count++;
      if (count >= 4) begin
        count = 0;
        return 1;
      end
      return 0;
    endfunction

    function void value_phase();
      case (cur_type)
        8'h01, 8'h09, 8'h11, 8'h12, 8'h3f: enter_fixed(8);
        8'h07: enter_fixed(12);
        8'h08: enter_fixed(1);
        8'h10: enter_fixed(4);
        8'h02, 8'h0d, 8'h0e: enter(bst_pkg::PH_STRLEN);
        8'h03, 8'h04: enter(bst_pkg::PH_LEN);
        8'h05: enter(bst_pkg::PH_BINLEN);
        8'h06, 8'h0a, 8'h7f, 8'hff: enter(bst_pkg::PH_TYPE);
        8'h0b: enter(bst_pkg::PH_RE1);
        8'h0c: enter(bst_pkg::PH_DBSTRLEN);
        8'h0f: enter(bst_pkg::PH_SCSIZE);
        default: err = bst_pkg::ERR_BAD_TYPE;
      endcase
    endfunction

    function logic [3:0] tag_byte(logic [7:0] b, inout logic [31:0] shown, inout bit done);
      logic [31:0] need;
      logic [31:0] left;
      case (phase)
        bst_pkg::PH_LEN: begin
          if (count == 0) begin
            depth++;
            shown = depth;
            if (depth > DEPTH_LIMIT) begin
              err = bst_pkg::ERR_TOO_DEEP;
              return bst_pkg::ROLE_DOC_LEN;
            end
          end
          if (word_byte(b)) begin
            need = acc - 4;
            left = buf_len - pos - 1;
            if (need > left) err = bst_pkg::ERR_TOO_SHORT;
            else if (acc < 5) err = bst_pkg::ERR_BAD_SIZE;
            else enter(bst_pkg::PH_TYPE);
          end
          return bst_pkg::ROLE_DOC_LEN;
        end
        bst_pkg::PH_TYPE: begin
          cur_type = b;
          if (b == 0) begin
            depth--;
            if (depth == 0) begin
              phase = bst_pkg::PH_DONE;
              done = 1;
            end
            return bst_pkg::ROLE_DOC_END;
          end
          enter(bst_pkg::PH_NAME);
          return bst_pkg::ROLE_TYPE;
        end
        bst_pkg::PH_NAME: begin
          if (b != 0) return bst_pkg::ROLE_NAME;
          value_phase();
          return bst_pkg::ROLE_NAME_END;
        end
        bst_pkg::PH_FIXED: begin
          count--;
          if (count == 0) enter(bst_pkg::PH_TYPE);
          return bst_pkg::ROLE_BODY;
        end
        bst_pkg::PH_STRLEN, bst_pkg::PH_DBSTRLEN, bst_pkg::PH_SCSTRLEN,
        bst_pkg::PH_BINLEN, bst_pkg::PH_SCSIZE: begin
          if (word_byte(b)) begin
            if (phase == bst_pkg::PH_BINLEN) phase = bst_pkg::PH_BINSUB;
            else if (phase == bst_pkg::PH_SCSIZE) enter(bst_pkg::PH_SCSTRLEN);
            else enter(bst_pkg::phase_t'(phase + 1));
          end
          return bst_pkg::ROLE_VAL_LEN;
        end
        bst_pkg::PH_STRBODY, bst_pkg::PH_DBSTRBODY, bst_pkg::PH_RE1,
        bst_pkg::PH_RE2, bst_pkg::PH_SCSTRBODY: begin
          if (b != 0) return bst_pkg::ROLE_BODY;
          if (phase == bst_pkg::PH_DBSTRBODY) enter_fixed(12);
          else if (phase == bst_pkg::PH_RE1) enter(bst_pkg::PH_RE2);
          else if (phase == bst_pkg::PH_SCSTRBODY) enter(bst_pkg::PH_LEN);
          else enter(bst_pkg::PH_TYPE);
          return bst_pkg::ROLE_STR_END;
        end
        bst_pkg::PH_BINSUB: begin
          if (!(b inside {8'h00, 8'h01, 8'h02, 8'h03, 8'h05, 8'h80}))
            err = bst_pkg::ERR_BAD_SUB;
          else if (acc == 0) enter(bst_pkg::PH_TYPE);
          else phase = bst_pkg::PH_BINBODY;
          return bst_pkg::ROLE_SUBTYPE;
        end
        bst_pkg::PH_BINBODY: begin
          acc--;
          if (acc == 0) enter(bst_pkg::PH_TYPE);
          return bst_pkg::ROLE_BODY;
        end
        default: return bst_pkg::ROLE_TRAILING;
      endcase
    endfunction

    // Note an accepted byte and queue its expected result.
    function void note_byte(bst_pkg::in_item_t it);
      bst_pkg::out_item_t r;
      logic [31:0]        shown;
      bit                 done;
      done = 0;
      if (it.first_byte) clear();
      shown = depth;
      r = '0;
      if (pos >= buf_len) begin
        r.byte_role = bst_pkg::ROLE_TRAILING;
        if (err == bst_pkg::ERR_NONE && phase != bst_pkg::PH_DONE) err = bst_pkg::ERR_UNEXP_END;
      end else if (err != bst_pkg::ERR_NONE || phase == bst_pkg::PH_DONE) begin
        r.byte_role = bst_pkg::ROLE_TRAILING;
      end else if (pos < skip_len) begin
        r.byte_role = bst_pkg::ROLE_SKIP;
      end else begin
        r.byte_role = tag_byte(it.data_byte, shown, done);
        if (done) r.end_offset = pos + 1;
      end
      if (pos < buf_len && pos == buf_len - 1 && err == bst_pkg::ERR_NONE &&
          phase != bst_pkg::PH_DONE)
        err = bst_pkg::ERR_UNEXP_END;
      if (pos != 32'hffff_ffff) pos++;
      r.element_type = cur_type;
      r.nest_depth = shown[5:0];
      r.error_code = err;
      r.doc_done = done;
      pending.push_back(r);
    endfunction

    function void check_result(bst_pkg::out_item_t got);
      bst_pkg::out_item_t e;
      if (pending.size() == 0) begin
        $error("result with nothing expected: %p", got);
        fails++;
        return;
      end
      e = pending.pop_front();
      if (got.byte_role !== e.byte_role) begin
        $error("byte_role exp %0d got %0d", e.byte_role, got.byte_role); fails++;
      end
      if (got.element_type !== e.element_type) begin
        $error("element_type exp %0h got %0h", e.element_type, got.element_type); fails++;
      end
      if (got.nest_depth !== e.nest_depth) begin
        $error("nest_depth exp %0d got %0d", e.nest_depth, got.nest_depth); fails++;
      end
      if (got.error_code !== e.error_code) begin
        $error("error_code exp %0d got %0d", e.error_code, got.error_code); fails++;
      end
      if (got.doc_done !== e.doc_done) begin
        $error("doc_done exp %0d got %0d", e.doc_done, got.doc_done); fails++;
      end
      if (got.end_offset !== e.end_offset) begin
        $error("end_offset exp %0h got %0h", e.end_offset, got.end_offset); fails++;
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_ready;
  bst_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 0;
  bst_pkg::out_item_t out_data;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic [7:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  token_scoreboard sb;
  int  send_idle_pct;
  int  recv_idle_pct;
  int  hold_off;
  int  quiet_cycles;
  int  sent;
  logic [7:0] doc_bytes[$];

  bson_stream_tokenizer #(.MAX_DEPTH(DEPTH_LIMIT)) dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // Drain results; honor a long hold-off when one is requested.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles with no transaction.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || rst)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Offer one byte; valid stays up after acceptance so back-to-back bytes need no gap.
  task automatic send_byte(logic [7:0] b, logic fb);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= '{data_byte: b, first_byte: fb};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte('{data_byte: b, first_byte: fb});
    sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    in_valid <= 0;
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    sb.write_reg(idx, val);
  endtask

  task automatic push_word(logic [31:0] w);
    for (int i = 0; i < 4; i++) doc_bytes.push_back(w[8*i +: 8]);
  endtask

  task automatic push_name();
    int n;
    n = $urandom_range(3);
    repeat (n) doc_bytes.push_back(8'($urandom_range(1, 255)));
    doc_bytes.push_back(8'h00);
  endtask

  task automatic push_cstr(int n);
    repeat (n) doc_bytes.push_back(8'($urandom_range(1, 255)));
    doc_bytes.push_back(8'h00);
  endtask

  // Append a well-formed document body (elements then terminator).
  task automatic push_doc(int lvl);
    int n;
    int k;
    logic [7:0] t;
    logic [7:0] types[] = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08,
                            8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d, 8'h0e, 8'h0f, 8'h10,
                            8'h11, 8'h12, 8'h3f, 8'h7f, 8'hff};
    logic [7:0] subs[] = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h05, 8'h80};
    push_word(32'($urandom_range(5, 40)));
    n = $urandom_range(4);
    repeat (n) begin
      t = types[$urandom_range(types.size() - 1)];
      if (lvl > 3 && (t == 8'h03 || t == 8'h04 || t == 8'h0f)) t = 8'h0a;
      doc_bytes.push_back(t);
      push_name();
      case (t)
        8'h01, 8'h09, 8'h11, 8'h12, 8'h3f:
          repeat (8) doc_bytes.push_back(8'($urandom));
        8'h07: repeat (12) doc_bytes.push_back(8'($urandom));
        8'h08: doc_bytes.push_back(8'($urandom));
        8'h10: repeat (4) doc_bytes.push_back(8'($urandom));
        8'h02, 8'h0d, 8'h0e: begin
          push_word($urandom);
          push_cstr($urandom_range(3));
        end
        8'h03, 8'h04: push_doc(lvl + 1);
        8'h05: begin
          k = $urandom_range(3);
          push_word(k);
          doc_bytes.push_back(subs[$urandom_range(subs.size() - 1)]);
          repeat (k) doc_bytes.push_back(8'($urandom));
        end
        8'h0b: begin
          push_cstr($urandom_range(2));
          push_cstr($urandom_range(2));
        end
        8'h0c: begin
          push_word($urandom);
          push_cstr($urandom_range(2));
          repeat (12) doc_bytes.push_back(8'($urandom));
        end
        8'h0f: begin
          push_word($urandom);
          push_word($urandom);
          push_cstr($urandom_range(2));
          push_doc(lvl + 1);
        end
        default: ;
      endcase
    end
    doc_bytes.push_back(8'h00);
  endtask

  // Send one buffer: skipped prefix, document, trailing bytes; sometimes corrupted or cut short.
  task automatic send_buffer(int skip, bit corrupt, bit cut);
    doc_bytes.delete();
    repeat (skip) doc_bytes.push_back(8'($urandom));
    push_doc(0);
    if (corrupt) doc_bytes[$urandom_range(skip, doc_bytes.size() - 1)] = 8'($urandom);
    if (cut) doc_bytes = doc_bytes[0:$urandom_range(doc_bytes.size() - 1)];
    repeat ($urandom_range(2)) doc_bytes.push_back(8'($urandom));
    foreach (doc_bytes[i]) send_byte(doc_bytes[i], i == 0);
  endtask

  task automatic random_phase(int items);
    int goal;
    int skip;
    goal = sent + items;
    while (sent < goal) begin
      if ($urandom_range(9) == 0) begin
        send_byte(8'($urandom), $urandom_range(1));
        drain();
      end else begin
        skip = $urandom_range(2);
        write_reg(bst_pkg::REG_START_OFFSET, skip);
        send_buffer(skip, $urandom_range(9) < 2, $urandom_range(9) == 0);
        drain();
      end
    end
  endtask

  initial begin
    sb = new();
    hold_off = 0;
    quiet_cycles = 0;
    sent = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: zero-length buffer, then offset past the end.
    write_reg(bst_pkg::REG_BUFFER_LENGTH, 0);
    send_byte(8'hff, 1);
    send_byte(8'h00, 0);
    drain();
    write_reg(bst_pkg::REG_BUFFER_LENGTH, 32'hffff_ffff);
    write_reg(bst_pkg::REG_START_OFFSET, 32'hffff_ffff);
    send_byte(8'h00, 1);
    send_byte(8'hff, 0);
    drain();
    // Size below five, and a size larger than the buffer.
    write_reg(bst_pkg::REG_BUFFER_LENGTH, 16);
    write_reg(bst_pkg::REG_START_OFFSET, 0);
    send_byte(8'h04, 1); send_byte(8'h00, 0); send_byte(8'h00, 0); send_byte(8'h00, 0);
    send_byte(8'h40, 1); send_byte(8'h00, 0); send_byte(8'h00, 0); send_byte(8'h00, 0);
    // Unknown type, then bad subtype.
    send_byte(8'h05, 1); send_byte(8'h00, 0); send_byte(8'h00, 0); send_byte(8'h00, 0);
    send_byte(8'h13, 0); send_byte(8'h00, 0);
    send_byte(8'h05, 1); send_byte(8'h00, 0); send_byte(8'h00, 0); send_byte(8'h00, 0);
    send_byte(8'h05, 0); send_byte(8'h00, 0);
    send_byte(8'h00, 0); send_byte(8'h00, 0); send_byte(8'h00, 0); send_byte(8'h00, 0);
    send_byte(8'h7e, 0);
    drain();
    // Too deep: nested documents past the limit.
    write_reg(bst_pkg::REG_BUFFER_LENGTH, 2000);
    for (int d = 0; d < DEPTH_LIMIT + 1; d++) begin
      send_byte(8'h05, d == 0); send_byte(8'h00, 0); send_byte(8'h00, 0);
      send_byte(8'h00, 0); send_byte(8'h03, 0); send_byte(8'h00, 0);
    end
    drain();

    write_reg(bst_pkg::REG_BUFFER_LENGTH, 4096);
    send_idle_pct = 33; recv_idle_pct = 67;
    random_phase(250);
    send_idle_pct = 67; recv_idle_pct = 33;
    random_phase(250);
    send_idle_pct = 0; recv_idle_pct = 0;
    // Hold the receiver off while the sender keeps offering bytes.
    hold_off = 300;
    send_buffer(0, 0, 0);
    drain();
    random_phase(250);
    // Short buffer ending mid-document.
    write_reg(bst_pkg::REG_BUFFER_LENGTH, 7);
    send_buffer(0, 0, 0);
    drain();

    repeat (20) @(posedge clk);
    if (sb.fails == 0 && sb.pending.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule

### filelist.f
rtl/bst_pkg.sv
rtl/bst_parse.sv
rtl/bson_stream_tokenizer.sv
tb/sv/tb.sv
